// ===== design/bir_pkg.sv =====
// Shared widths, codes and the coordinate-map result type for the bilinear rotator.
// No dependencies; imported by bir_map and bilinear_image_rotator.
package bir_pkg;

   localparam int CSR_W      = 16;   // cosine / sine register width, Q2.14
   localparam int CSR_IDX_W  = 1;
   localparam int PIX_W      = 16;   // Q0.16 pixel
   localparam int POS_W      = 5;    // col / row field width
   localparam int OFS_W      = 11;   // doubled offset from the center, signed
   localparam int PROD_W     = 27;   // CSR_W x OFS_W signed product
   localparam int FRAC_W     = 14;   // interpolation fraction
   localparam int INT_W      = 14;   // integer part of a source coordinate
   localparam int COORD_W    = 29;   // Q.15 source coordinate, signed
   localparam int FRAC_ONE   = 16384;
   localparam int WGT_W      = 29;   // product of two weights, Q.28
   localparam int TERM_W     = 45;   // weight x pixel
   localparam int ACC_W      = 47;
   localparam int SUM_SHIFT  = 28;
   localparam int ROUND      = 1 << 27;
   localparam int NBR_N      = 4;    // neighbors per output pixel
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   localparam logic OP_STORE   = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_COS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SIN = 1'b1;

   // Neighbor order: (x0,y0), (x0+1,y0), (x0,y0+1), (x0+1,y0+1)
   typedef struct packed {
      logic [NBR_N-1:0][WGT_W-1:0] wgt;
      logic [NBR_N-1:0]            inb;
   } map_type;

endpackage

// ===== design/bilinear_image_rotator.sv =====
// Bilinear image rotator top level: request decode, single-port image memory,
// neighbor fetch and blend, result register. Depends on bir_pkg and bir_map.
//
//  group  direction  handshake              payload
//  req    in         req_tvalid/req_tready  tdata: col, row, pixel; tuser: operation
//  rsp    out        rsp_tvalid/rsp_tready  tdata: rotated_value
//  csr    in         csr_wen                csr_index, csr_wdata
//
// A store request is written on accept and leaves the block ready. A compute request
// passes through the coordinate map, four single-port reads and the multiply-accumulate
// drain and load, and no new request is accepted until its result is loaded.
// Synchronous active-high reset clears control and sets the angle registers to cos one,
// sin zero; the image memory is not cleared. The next request is accepted while a result
// waits; a stalled rsp holds the block only when a second result is ready to load.
module bilinear_image_rotator import bir_pkg::*; #(
   parameter int SIDE = 28
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // [4:0] col, [9:5] row, [25:10] pixel
   input  logic                    req_tuser,   // [0] operation
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // [15:0] rotated_value
   input  logic                    csr_wen,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   localparam int DEPTH = SIDE * SIDE;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MAP   = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [POS_W-1:0]         req_col, req_row;
   logic [PIX_W-1:0]         req_pixel;
   logic                     accept, mem_we, map_start, map_done, out_load;
   logic [1:0]               state_ff, state_in;
   logic [1:0]               cnt_ff, cnt_in;
   logic signed [CSR_W-1:0]  cos_ff, sin_ff;
   map_type                  info;
   logic [AW-1:0]            base_addr, rd_addr, wr_addr, mem_addr;
   logic [PIX_W-1:0]         mem [DEPTH];
   logic [PIX_W-1:0]         rd_data_ff;
   logic                     s1_ff, inb1_ff, pv_ff;
   logic [WGT_W-1:0]         wgt1_ff;
   logic [TERM_W-1:0]        prod_ff;
   logic [ACC_W-1:0]         acc_ff, acc_rnd;
   logic [ACC_W-SUM_SHIFT-1:0] scaled;
   logic [RSP_DATA_W-1:0]    result;
   logic                     rsp_valid_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;

   assign req_col   = req_tdata[POS_W-1:0];
   assign req_row   = req_tdata[2*POS_W-1:POS_W];
   assign req_pixel = req_tdata[2*POS_W+PIX_W-1:2*POS_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   // drop stores outside the image
   assign mem_we     = accept && (req_tuser == OP_STORE) &&
                       (req_col < SIDE) && (req_row < SIDE);
   assign map_start  = accept && (req_tuser == OP_COMPUTE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff <= CSR_W'(FRAC_ONE);
         sin_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            REG_COS: cos_ff <= csr_wdata;
            REG_SIN: sin_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   bir_map #(.SIDE(SIDE)) u_map (
      .clock     (clock),
      .reset     (reset),
      .start     (map_start),
      .col       (req_col),
      .row       (req_row),
      .cos_angle (cos_ff),
      .sin_angle (sin_ff),
      .done      (map_done),
      .info      (info),
      .base_addr (base_addr)
   );

   assign wr_addr = AW'(32'(req_row) * SIDE + 32'(req_col));

   always_comb begin
      case (cnt_ff)
         2'd0:    rd_addr = base_addr;
         2'd1:    rd_addr = base_addr + AW'(1);
         2'd2:    rd_addr = base_addr + AW'(SIDE);
         default: rd_addr = base_addr + AW'(SIDE + 1);
      endcase
   end

   assign mem_addr = (state_ff == ST_READ) ? rd_addr : wr_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= req_pixel;
      end
      rd_data_ff <= mem[mem_addr];
   end

   // fetch pipeline: read, weight x pixel, accumulate
   always_ff @(posedge clock) begin
      inb1_ff <= info.inb[cnt_ff];
      wgt1_ff <= info.wgt[cnt_ff];
      prod_ff <= inb1_ff ? TERM_W'(wgt1_ff) * TERM_W'(rd_data_ff) : '0;
      if (map_done) begin
         acc_ff <= '0;
      end else if (pv_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   assign acc_rnd = acc_ff + ACC_W'(ROUND);
   assign scaled  = acc_rnd[ACC_W-1:SUM_SHIFT];
   assign result  = (|scaled[ACC_W-SUM_SHIFT-1:RSP_DATA_W]) ? '1 : scaled[RSP_DATA_W-1:0];

   assign out_load = (state_ff == ST_DRAIN) && !s1_ff && !pv_ff &&
                     (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (map_start) state_in = ST_MAP;
         end
         ST_MAP: begin
            if (map_done) begin
               state_in = ST_READ;
               cnt_in   = '0;
            end
         end
         ST_READ: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'(NBR_N - 1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         s1_ff        <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         s1_ff    <= (state_ff == ST_READ);
         pv_ff    <= s1_ff;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_map_done_in_map: assert property (@(posedge clock) disable iff (reset)
      map_done |-> (state_ff == ST_MAP))
      else $error("coordinate map finished outside the map wait");

   a_result_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DRAIN))
      else $error("result appeared without a finished blend");

   a_mac_in_window: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> (state_ff == ST_READ || state_ff == ST_DRAIN))
      else $error("accumulate outside the fetch window");

   a_four_reads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && $past(state_ff) == ST_READ) |-> ($past(cnt_ff) == 2'd3))
      else $error("left the fetch phase before all four neighbors");

endmodule

// ===== design/bir_map.sv =====
// Three-stage coordinate map: back-rotation products, source coordinate sums,
// then neighbor weights, bounds flags and base address. Depends on bir_pkg.
module bir_map import bir_pkg::*; #(
   parameter  int SIDE = 28,
   localparam int AW   = $clog2(SIDE * SIDE)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [POS_W-1:0]         col,
   input  logic [POS_W-1:0]         row,
   input  logic signed [CSR_W-1:0]  cos_angle,
   input  logic signed [CSR_W-1:0]  sin_angle,
   output logic                     done,
   output map_type                  info,
   output logic [AW-1:0]            base_addr
);

   localparam logic signed [COORD_W-1:0] CENTRE = COORD_W'((SIDE - 1) * FRAC_ONE);

   logic signed [OFS_W-1:0]   dx2, dy2;
   logic signed [PROD_W-1:0]  pcx_ff, psy_ff, psx_ff, pcy_ff;
   logic signed [COORD_W-1:0] sx_in, sy_in, sx_ff, sy_ff;
   logic signed [INT_W-1:0]   x0, y0;
   logic [FRAC_W-1:0]         fx, fy;
   logic [FRAC_W:0]           wx0, wx1, wy0, wy1;
   logic                      x0ok, x1ok, y0ok, y1ok;
   map_type                   info_in, info_ff;
   logic [AW-1:0]             base_in, base_ff;
   logic                      v1_ff, v2_ff, v3_ff;

   assign dx2 = signed'(OFS_W'({col, 1'b0})) - signed'(OFS_W'(SIDE - 1));
   assign dy2 = signed'(OFS_W'({row, 1'b0})) - signed'(OFS_W'(SIDE - 1));

   assign sx_in = COORD_W'(pcx_ff) + COORD_W'(psy_ff) + CENTRE;
   assign sy_in = COORD_W'(pcy_ff) - COORD_W'(psx_ff) + CENTRE;

   // split Q.15 into floor and a 14-bit truncated fraction
   assign x0  = sx_ff[COORD_W-1:FRAC_W+1];
   assign y0  = sy_ff[COORD_W-1:FRAC_W+1];
   assign fx  = sx_ff[FRAC_W:1];
   assign fy  = sy_ff[FRAC_W:1];
   assign wx1 = {1'b0, fx};
   assign wy1 = {1'b0, fy};
   assign wx0 = (FRAC_W + 1)'(FRAC_ONE) - wx1;
   assign wy0 = (FRAC_W + 1)'(FRAC_ONE) - wy1;

   assign x0ok = (x0 >= 0)  && (x0 < SIDE);
   assign x1ok = (x0 >= -1) && (x0 < SIDE - 1);
   assign y0ok = (y0 >= 0)  && (y0 < SIDE);
   assign y1ok = (y0 >= -1) && (y0 < SIDE - 1);

   always_comb begin
      info_in.wgt[0] = WGT_W'(wx0) * WGT_W'(wy0);
      info_in.wgt[1] = WGT_W'(wx1) * WGT_W'(wy0);
      info_in.wgt[2] = WGT_W'(wx0) * WGT_W'(wy1);
      info_in.wgt[3] = WGT_W'(wx1) * WGT_W'(wy1);
      info_in.inb    = {x1ok & y1ok, x0ok & y1ok, x1ok & y0ok, x0ok & y0ok};
      // wraps when out of range; those neighbors are masked by inb
      base_in        = AW'(32'(y0) * SIDE + 32'(x0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         pcx_ff <= PROD_W'(cos_angle) * PROD_W'(dx2);
         psy_ff <= PROD_W'(sin_angle) * PROD_W'(dy2);
         psx_ff <= PROD_W'(sin_angle) * PROD_W'(dx2);
         pcy_ff <= PROD_W'(cos_angle) * PROD_W'(dy2);
      end
      if (v1_ff) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
      if (v2_ff) begin
         info_ff <= info_in;
         base_ff <= base_in;
      end
   end

   assign done      = v3_ff;
   assign info      = info_ff;
   assign base_addr = base_ff;

endmodule

// ===== sim/bilinear_image_rotator_tb.sv =====
// Self-checking testbench for bilinear_image_rotator: directed table, then random
// store/compute traffic over a series of angle settings; a compute that would read
// an unwritten pixel is replaced by a store there. Depends on bir_pkg and the RTL.
module bilinear_image_rotator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bir_pkg::*;

   localparam int SIDE         = 28;
   localparam int PIXELS       = SIDE * SIDE;
   localparam int POS_MAX      = (1 << POS_W) - 1;
   localparam int PIX_MAX      = (1 << PIX_W) - 1;
   localparam int QSHIFT       = 15;     // Q.15 source coordinates
   localparam int SETTLE       = 16;     // pipeline drain wait after the last result
   localparam int IDLE_LIMIT   = 3000;
   localparam int CHOKE_CYCLES = 300;
   localparam int PHASE_ITEMS  = 56;
   localparam int NUM_PHASES   = 10;
   localparam int NUM_DIRECTED = 19;

   typedef struct {
      logic                  op;
      logic [POS_W-1:0]      col;
      logic [POS_W-1:0]      row;
      logic [PIX_W-1:0]      pix;
      bit                    typed;
      logic [RSP_DATA_W-1:0] want;
   } plan_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = OP_STORE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = REG_COS;
   logic [CSR_W-1:0]      csr_wdata  = '0;

   // predictor state
   logic signed [CSR_W-1:0] cos_q = CSR_W'(FRAC_ONE);
   logic signed [CSR_W-1:0] sin_q = '0;
   logic [PIX_W-1:0]        image [PIXELS];
   bit                      written [PIXELS];
   logic [RSP_DATA_W-1:0]   pending_pixels [$];
   logic [RSP_DATA_W-1:0]   expected_pixel;

   int errors         = 0;
   int printed        = 0;
   int stores_sent    = 0;
   int computes_sent  = 0;
   int results_seen   = 0;
   int settings_used  = 0;
   int stalls_asked   = 0;
   int stalls_served  = 0;
   int idle_cycles    = 0;

   // identity angle after reset: compute at (c,r) returns the stored pixel at (c,r)
   plan_row_type directed_plan [NUM_DIRECTED] = '{
      '{OP_STORE,   0,  0, 16'h0000, 0, 16'h0000},
      '{OP_STORE,   1,  0, 16'hFFFF, 0, 16'h0000},
      '{OP_STORE,   0,  1, 16'hFFFF, 0, 16'h0000},
      '{OP_STORE,   1,  1, 16'h0000, 0, 16'h0000},
      '{OP_COMPUTE, 0,  0, 16'hFFFF, 1, 16'h0000},
      '{OP_STORE,  27, 27, 16'hFFFF, 0, 16'h0000},
      '{OP_COMPUTE,27, 27, 16'h0000, 1, 16'hFFFF},
      '{OP_STORE,  31, 31, 16'h1234, 0, 16'h0000},
      '{OP_STORE,  28,  5, 16'hAAAA, 0, 16'h0000},
      '{OP_STORE,   3, 30, 16'h5555, 0, 16'h0000},
      '{OP_COMPUTE,31, 31, 16'hA5A5, 1, 16'h0000},
      '{OP_COMPUTE,28,  0, 16'h0000, 1, 16'h0000},
      '{OP_COMPUTE, 0, 31, 16'h0000, 1, 16'h0000},
      '{OP_STORE,  26, 27, 16'h5555, 0, 16'h0000},
      '{OP_COMPUTE,26, 27, 16'h0000, 0, 16'h0000},
      '{OP_STORE,  27, 26, 16'hAAAA, 0, 16'h0000},
      '{OP_STORE,  26, 26, 16'h00FF, 0, 16'h0000},
      '{OP_COMPUTE,26, 26, 16'h0000, 0, 16'h0000},
      '{OP_COMPUTE,27, 26, 16'h0000, 0, 16'h0000}
   };

   logic [CSR_W-1:0] phase_cos [NUM_PHASES] = '{
      16'h0000, 16'hC000, 16'h0000, 16'h2D41, 16'h4000,
      16'hC000, 16'h7FFF, 16'h0000, 16'h0000, 16'h4000
   };
   logic [CSR_W-1:0] phase_sin [NUM_PHASES] = '{
      16'h4000, 16'h0000, 16'hC000, 16'h2D41, 16'h4000,
      16'hC000, 16'h8000, 16'h0000, 16'h0000, 16'h0000
   };

   bilinear_image_rotator #(.SIDE(SIDE)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint neighbor(longint x, longint y);
      if (x < 0 || x >= SIDE || y < 0 || y >= SIDE) return 0;
      return longint'(image[y * SIDE + x]);
   endfunction

   // map the output position back through the angle and blend four neighbors
   function automatic logic [RSP_DATA_W-1:0] rotate_pixel(logic [POS_W-1:0] col,
                                                           logic [POS_W-1:0] row);
      longint dx2, dy2, sx, sy, x0, y0, fx, fy, acc, sum;
      longint wx [2];
      longint wy [2];
      dx2 = 2 * longint'(col) - (SIDE - 1);
      dy2 = 2 * longint'(row) - (SIDE - 1);
      sx = longint'(cos_q) * dx2 + longint'(sin_q) * dy2 + (SIDE - 1) * FRAC_ONE;
      sy = -longint'(sin_q) * dx2 + longint'(cos_q) * dy2 + (SIDE - 1) * FRAC_ONE;
      x0 = sx >>> QSHIFT;
      y0 = sy >>> QSHIFT;
      fx = (sx & ((1 << QSHIFT) - 1)) >> 1;
      fy = (sy & ((1 << QSHIFT) - 1)) >> 1;
      wx[0] = FRAC_ONE - fx;
      wx[1] = fx;
      wy[0] = FRAC_ONE - fy;
      wy[1] = fy;
      acc = 0;
      for (int j = 0; j < 2; j++)
         for (int i = 0; i < 2; i++)
            acc += wx[i] * wy[j] * neighbor(x0 + i, y0 + j);
      sum = (acc + ROUND) >>> SUM_SHIFT;
      if (sum > PIX_MAX) sum = PIX_MAX;
      return sum[RSP_DATA_W-1:0];
   endfunction

   // index of an in-image neighbor of this compute that was never written, else -1
   function automatic int unwritten_neighbor(logic [POS_W-1:0] col, logic [POS_W-1:0] row);
      longint dx2, dy2, sx, sy, x0, y0, x, y;
      dx2 = 2 * longint'(col) - (SIDE - 1);
      dy2 = 2 * longint'(row) - (SIDE - 1);
      sx = longint'(cos_q) * dx2 + longint'(sin_q) * dy2 + (SIDE - 1) * FRAC_ONE;
      sy = -longint'(sin_q) * dx2 + longint'(cos_q) * dy2 + (SIDE - 1) * FRAC_ONE;
      x0 = sx >>> QSHIFT;
      y0 = sy >>> QSHIFT;
      for (int j = 0; j < 2; j++)
         for (int i = 0; i < 2; i++) begin
            x = x0 + i;
            y = y0 + j;
            if (x >= 0 && x < SIDE && y >= 0 && y < SIDE && !written[y * SIDE + x])
               return int'(y * SIDE + x);
         end
      return -1;
   endfunction

   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [PIX_W-1:0] random_pixel();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 16) return PIX_W'(PIX_MAX);
      return PIX_W'($urandom_range(0, PIX_MAX));
   endfunction

   task automatic report_mismatch(string what, logic [RSP_DATA_W-1:0] got,
                                  logic [RSP_DATA_W-1:0] want);
      errors++;
      if (printed < 30) begin
         printed++;
         $display("mismatch at %0t: %s: got %h expected %h", $realtime, what, got, want);
      end
   endtask

   // offer one request, hold it until accepted, then update the image or queue the pixel
   task automatic send_req(logic op, logic [POS_W-1:0] col, logic [POS_W-1:0] row,
                           logic [PIX_W-1:0] pix, int gap, bit typed,
                           logic [RSP_DATA_W-1:0] want);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({pix, row, col});
      do @(posedge clock); while (!req_tready);
      if (op == OP_STORE) begin
         stores_sent++;
         if (col < SIDE && row < SIDE) begin
            image[row * SIDE + col] = pix;
            written[row * SIDE + col] = 1'b1;
         end
      end else begin
         computes_sent++;
         pending_pixels.push_back(typed ? want : rotate_pixel(col, row));
      end
   endtask

   // drop valid, wait for every pending pixel, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_angle(logic [CSR_W-1:0] c, logic [CSR_W-1:0] s);
      csr_wen   <= 1'b1;
      csr_index <= REG_COS;
      csr_wdata <= c;
      @(posedge clock);
      cos_q = c;
      csr_index <= REG_SIN;
      csr_wdata <= s;
      @(posedge clock);
      sin_q = s;
      csr_wen <= 1'b0;
      settings_used++;
   endtask

   task automatic random_request(bit quiet, output bit counted);
      int r;
      int hole;
      logic [POS_W-1:0] col, row;
      r = $urandom_range(0, 99);
      counted = 1'b1;
      if (r < 65) begin
         col = POS_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, SIDE - 1)
                                                   : $urandom_range(0, POS_MAX));
         row = POS_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, SIDE - 1)
                                                   : $urandom_range(0, POS_MAX));
         hole = unwritten_neighbor(col, row);
         if (hole < 0) begin
            send_req(OP_COMPUTE, col, row, PIX_W'($urandom), pick_gap(quiet), 1'b0, '0);
         end else begin
            // fill the pixel that this compute would read first
            send_req(OP_STORE, POS_W'(hole % SIDE), POS_W'(hole / SIDE), random_pixel(),
                     pick_gap(quiet), 1'b0, '0);
         end
      end else if (r < 95) begin
         col = POS_W'($urandom_range(0, SIDE - 1));
         row = POS_W'($urandom_range(0, SIDE - 1));
         send_req(OP_STORE, col, row, random_pixel(), pick_gap(quiet), 1'b0, '0);
      end else begin
         // store outside the image: dropped by the block
         if ($urandom_range(0, 1)) begin
            col = POS_W'($urandom_range(SIDE, POS_MAX));
            row = POS_W'($urandom_range(0, POS_MAX));
         end else begin
            col = POS_W'($urandom_range(0, POS_MAX));
            row = POS_W'($urandom_range(SIDE, POS_MAX));
         end
         send_req(OP_STORE, col, row, random_pixel(), pick_gap(quiet), 1'b0, '0);
         counted = 1'b0;
      end
   endtask

   // receiver: random ready pattern, plus a long hold-off on request from the stimulus
   initial begin
      int r, n;
      forever begin
         if (stalls_served != stalls_asked) begin
            stalls_served++;
            rsp_tready <= 1'b0;
            repeat (CHOKE_CYCLES) @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               rsp_tready <= 1'b1;
               n = $urandom_range(1, 20);
            end else if (r < 60) begin
               rsp_tready <= 1'b1;
               n = $urandom_range(40, 120);
            end else if (r < 92) begin
               rsp_tready <= 1'b0;
               n = $urandom_range(1, 3);
            end else begin
               rsp_tready <= 1'b0;
               n = $urandom_range(8, 40);
            end
            repeat (n) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_pixels.size() == 0) begin
            report_mismatch("result with no request pending", rsp_tdata, '0);
         end else begin
            expected_pixel = pending_pixels.pop_front();
            if (rsp_tdata !== expected_pixel)
               report_mismatch("rotated_value", rsp_tdata, expected_pixel);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results pending",
                  idle_cycles, pending_pixels.size());
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int count;
      bit counted, quiet;
      logic [CSR_W-1:0] c, s;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: runs with the reset angle
      foreach (directed_plan[i])
         send_req(directed_plan[i].op, directed_plan[i].col, directed_plan[i].row,
                  directed_plan[i].pix, pick_gap(1'b0), directed_plan[i].typed,
                  directed_plan[i].want);
      settle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         c = phase_cos[p];
         s = phase_sin[p];
         if (p == 7) begin
            c = CSR_W'(int'($urandom_range(0, 2 * FRAC_ONE)) - FRAC_ONE);
            s = CSR_W'(int'($urandom_range(0, 2 * FRAC_ONE)) - FRAC_ONE);
         end else if (p == 8) begin
            c = CSR_W'($urandom);
            s = CSR_W'($urandom);
         end
         set_angle(c, s);
         quiet = (p == 3 || p == 5);
         // back-pressure: hold the result side while requests keep coming
         if (p == 3) stalls_asked++;
         count = 0;
         while (count < PHASE_ITEMS) begin
            random_request(quiet, counted);
            count += counted;
         end
         settle();
      end

      $display("summary: %0d stores, %0d computes, %0d results checked, %0d angle settings",
               stores_sent, computes_sent, results_seen, settings_used);
      $display("summary: quarter turns, 45 degrees, full-scale and out-of-range angle words");
      if (errors == 0 && pending_pixels.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/bir_pkg.sv
design/bir_map.sv
design/bilinear_image_rotator.sv
sim/bilinear_image_rotator_tb.sv
